// ===== sv/sha1sh_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared constants, types and helper functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    localparam int unsigned NUM_CHAIN = 5;
    localparam int unsigned NUM_WORDS = 16;
    localparam int unsigned LAST_RND  = 79;

    typedef logic [31:0] word_t;

    localparam word_t INIT_H [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Round groups of 20 rounds each
    typedef enum logic [1:0] {
        GRP_CH  = 2'd0,
        GRP_P1  = 2'd1,
        GRP_MAJ = 2'd2,
        GRP_P2  = 2'd3
    } rgrp_t;

    function automatic word_t rol1(input word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rol5(input word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rol30(input word_t x);
        return {x[1:0], x[31:2]};
    endfunction

    function automatic rgrp_t round_grp(input logic [6:0] rnd);
        rgrp_t g;
        if (rnd < 7'd20)
        begin
            g = GRP_CH;
        end
        else if (rnd < 7'd40)
        begin
            g = GRP_P1;
        end
        else if (rnd < 7'd60)
        begin
            g = GRP_MAJ;
        end
        else
        begin
            g = GRP_P2;
        end
        return g;
    endfunction

    function automatic word_t round_f(input rgrp_t g, input word_t b, input word_t c,
                                      input word_t d);
        word_t f;
        unique case (g)
            GRP_CH:  f = (b & c) | (~b & d);
            GRP_MAJ: f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/sha1_stream_hash.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hash
// SHA-1 digest of a byte stream, one byte per request, five digest words out.
// ----------------------------------------------------------------------------
// A byte request is taken while the block is idle (item_ready high). Bytes
// are packed big-endian and every fourth byte is written as a word into a
// 16 x 32 message schedule memory. When a 64-byte block is full the block
// stops taking requests and compresses it: it loads the working variables,
// runs 16 rounds on the stored words, then 64 rounds that each also compute
// a new schedule word, and folds into the chaining words. Rounds 16 to 79
// each need an extra read phase, since each new schedule word needs four
// words from the memory, which has two registered read ports. A request with
// end_of_message set appends its byte (if has_byte), then writes the 0x80
// pad, zero words and the 64-bit bit length into the memory one word per
// cycle and runs one or two final compressions; two when the pad byte lands
// at byte 56 or later of the last block, so the length no longer fits behind
// it. The five digest words then appear on the digest channel, h0 first, one
// per digest handshake, and the block returns to its initial chaining values
// with a zero length for the next message. A request with neither has_byte
// nor end_of_message changes nothing.
module sha1_stream_hash
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,

    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,   // taking byte requests
        ST_FILL = 6'b000010,   // writing pad / length words
        ST_PREP = 6'b000100,   // load working vars, first schedule read
        ST_RUN  = 6'b001000,   // 80 rounds
        ST_ADD  = 6'b010000,   // fold into chaining words
        ST_OUT  = 6'b100000    // hand out digest words
    } state_t;

    state_t      state_reg, state_next;

    // message length in bytes, wraps mod 2^61
    logic [60:0] count_reg, count_next;
    // bytes of the word being assembled, newest in the low byte
    logic [23:0] part_reg, part_next;

    logic [6:0]  rnd_reg, rnd_next;
    logic        ph_reg, ph_next;       // second half of a scheduled round
    logic [3:0]  widx_reg, widx_next;   // fill pointer
    logic [2:0]  oidx_reg, oidx_next;   // digest word pointer

    logic        fin_reg, fin_next;     // end request pending
    logic        padded_reg, padded_next; // pad word already written
    logic        lenw_reg, lenw_next;   // length words already written
    logic        two_reg, two_next;     // second final block being filled

    word_t       chain_reg [NUM_CHAIN];
    word_t       chain_next [NUM_CHAIN];
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t       a_next, b_next, c_next, d_next, e_next;
    word_t       x_reg, x_next;         // first half of the schedule xor

    // message schedule memory, two registered read ports, one write port
    word_t       w_mem [NUM_WORDS];
    word_t       rd_a_reg, rd_b_reg;
    logic        mem_we;
    logic [3:0]  mem_wa, mem_ra, mem_rb;
    word_t       mem_wd;

    // datapath helpers
    logic [5:0]  pos;
    logic        len_here;
    logic [63:0] bit_len;
    word_t       pad_word;
    word_t       fill_word;
    word_t       wj;
    word_t       t_sum;
    rgrp_t       grp;
    logic        do_round;

    assign pos      = count_reg[5:0];
    assign bit_len  = {count_reg, 3'b000};
    // length fits behind the pad word only if the pad lands before byte 56
    assign len_here = two_reg || (count_reg[5:3] != 3'b111);

    always_comb
    begin
        unique case (count_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {part_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {part_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {part_reg, PAD_BYTE};
        endcase
    end

    always_comb
    begin
        if (!two_reg && (widx_reg == count_reg[5:2]))
        begin
            fill_word = pad_word;
        end
        else if (len_here && (widx_reg == 4'd14))
        begin
            fill_word = bit_len[63:32];
        end
        else if (len_here && (widx_reg == 4'd15))
        begin
            fill_word = bit_len[31:0];
        end
        else
        begin
            fill_word = '0;
        end
    end

    // round datapath
    assign grp   = round_grp(rnd_reg);
    assign wj    = (rnd_reg < 7'd16) ? rd_a_reg : rol1(x_reg ^ rd_a_reg ^ rd_b_reg);
    assign t_sum = rol5(a_reg) + round_f(grp, b_reg, c_reg, d_reg) + e_reg
                   + ROUND_K[grp] + wj;

    assign item_ready   = (state_reg == ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);
    assign digest_word  = chain_reg[oidx_reg];
    assign word_index   = oidx_reg;
    assign last_word    = (oidx_reg == 3'd4);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        part_next   = part_reg;
        rnd_next    = rnd_reg;
        ph_next     = ph_reg;
        widx_next   = widx_reg;
        oidx_next   = oidx_reg;
        fin_next    = fin_reg;
        padded_next = padded_reg;
        lenw_next   = lenw_reg;
        two_next    = two_reg;
        chain_next  = chain_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        x_next      = x_reg;
        mem_we      = 1'b0;
        mem_wa      = widx_reg;
        mem_wd      = fill_word;
        mem_ra      = 4'd0;
        mem_rb      = 4'd0;
        do_round    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (has_byte)
                    begin
                        count_next = count_reg + 61'd1;
                        if (pos[1:0] == 2'd3)
                        begin
                            mem_we = 1'b1;
                            mem_wa = pos[5:2];
                            mem_wd = {part_reg, data_byte};
                        end
                        else
                        begin
                            part_next = {part_reg[15:0], data_byte};
                        end
                    end
                    fin_next    = end_of_message;
                    padded_next = 1'b0;
                    lenw_next   = 1'b0;
                    two_next    = 1'b0;
                    if (has_byte && (pos == 6'd63))
                    begin
                        state_next = ST_PREP;
                    end
                    else if (end_of_message)
                    begin
                        widx_next  = count_next[5:2];
                        state_next = ST_FILL;
                    end
                end
            end

            ST_FILL:
            begin
                mem_we    = 1'b1;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'd15)
                begin
                    padded_next = 1'b1;
                    lenw_next   = len_here;
                    state_next  = ST_PREP;
                end
            end

            ST_PREP:
            begin
                mem_ra     = 4'd0;
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                rnd_next   = '0;
                ph_next    = 1'b0;
                state_next = ST_RUN;
            end

            ST_RUN:
            begin
                if (rnd_reg < 7'd16)
                begin
                    do_round = 1'b1;
                    rnd_next = rnd_reg + 7'd1;
                    if (rnd_reg == 7'd15)
                    begin
                        mem_ra = rnd_reg[3:0] + 4'd14;
                        mem_rb = rnd_reg[3:0] + 4'd9;
                    end
                    else
                    begin
                        mem_ra = rnd_reg[3:0] + 4'd1;
                    end
                end
                else if (!ph_reg)
                begin
                    // w[j+13] ^ w[j+8] is in, fetch w[j+2] and w[j]
                    x_next  = rd_a_reg ^ rd_b_reg;
                    mem_ra  = rnd_reg[3:0] + 4'd2;
                    mem_rb  = rnd_reg[3:0];
                    ph_next = 1'b1;
                end
                else
                begin
                    do_round = 1'b1;
                    mem_we   = 1'b1;
                    mem_wa   = rnd_reg[3:0];
                    mem_wd   = wj;
                    mem_ra   = rnd_reg[3:0] + 4'd14;
                    mem_rb   = rnd_reg[3:0] + 4'd9;
                    ph_next  = 1'b0;
                    rnd_next = rnd_reg + 7'd1;
                    if (rnd_reg == 7'(LAST_RND))
                    begin
                        state_next = ST_ADD;
                    end
                end
            end

            ST_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                priority if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (lenw_reg)
                begin
                    oidx_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // pad after a full block, or length-only second block
                    widx_next  = padded_reg ? 4'd0 : count_reg[5:2];
                    two_next   = padded_reg;
                    state_next = ST_FILL;
                end
            end

            ST_OUT:
            begin
                if (digest_ready)
                begin
                    if (oidx_reg == 3'd4)
                    begin
                        for (int i = 0; i < NUM_CHAIN; i++)
                        begin
                            chain_next[i] = INIT_H[i];
                        end
                        count_next = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_round)
        begin
            a_next = t_sum;
            b_next = a_reg;
            c_next = rol30(b_reg);
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rnd_reg    <= '0;
            ph_reg     <= 1'b0;
            widx_reg   <= '0;
            oidx_reg   <= '0;
            fin_reg    <= 1'b0;
            padded_reg <= 1'b0;
            lenw_reg   <= 1'b0;
            two_reg    <= 1'b0;
            for (int i = 0; i < NUM_CHAIN; i++)
            begin
                chain_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rnd_reg    <= rnd_next;
            ph_reg     <= ph_next;
            widx_reg   <= widx_next;
            oidx_reg   <= oidx_next;
            fin_reg    <= fin_next;
            padded_reg <= padded_next;
            lenw_reg   <= lenw_next;
            two_reg    <= two_next;
            chain_reg  <= chain_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        x_reg    <= x_next;
    end

    // schedule memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            w_mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= w_mem[mem_ra];
        rd_b_reg <= w_mem[mem_rb];
    end

endmodule

// ===== tb/tb_sha1_stream_hash.sv =====
// ----------------------------------------------------------------------------
// tb_sha1_stream_hash
// Self-checking bench for the SHA-1 byte stream hasher. A short table of
// directed requests (known digests, idle and bare end requests, byte
// extremes) is followed by random messages, the first ones with lengths
// around the padding boundaries. A SHA-1 predictor inside the bench computes
// the five digest words of every message. Random stalls are applied on both
// channels, plus one long digest-side stall that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha1_stream_hash
    import sha1sh_pkg::*;
();

    localparam int ITEMS_TARGET = 430;   // non-idle byte / end requests to send
    localparam int QUIET_AT     = 370;   // no more idling after this many
    localparam int LONG_HOLD    = 600;   // digest-side stall that backs up the input
    localparam int DRAIN_CYCLES = 400;   // covers a two-block tail
    localparam int MAX_REPORTS  = 10;

    // Standard SHA-1 test vectors: "" and "abc"
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        item_valid     = 1'b0;
    logic        item_ready;
    logic [7:0]  data_byte      = 8'h00;
    logic        has_byte       = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_valid;
    logic        digest_ready   = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha1_stream_hash dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_ready   (digest_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // SHA-1 predictor state: chaining words, the 16-word block being filled
    // and the 61-bit byte count of the current message (wraps naturally).
    // ------------------------------------------------------------------------
    word_t       sha_chain [NUM_CHAIN];
    word_t       sha_block [NUM_WORDS];
    logic [60:0] msg_len;

    typedef struct packed {
        word_t      word;
        logic [2:0] idx;
        logic       last;
    } digest_exp_t;

    digest_exp_t digest_due [$];   // digest words still to come, oldest first

    // Directed request table; digest typed in only for the known vectors
    typedef struct packed {
        logic [7:0]   data;
        logic         has;
        logic         eom;
        logic         known;
        logic [159:0] digest;
    } dir_row_t;

    localparam int NUM_DIR = 17;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},          // idle request before anything
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // empty message
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},          // "a"
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},          // "b"
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},      // "c" closes "abc"
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},          // one byte, all ones
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},          // one byte, all zeros
        '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},          // idle, data must be ignored
        '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hAA, 1'b0, 1'b0, 1'b0, 160'h0},          // idle inside a message
        '{8'hAA, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h3C, 1'b0, 1'b1, 1'b0, 160'h0},          // bare end after bytes
        '{8'hC3, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},    // state back to reset after digest
        '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h7F, 1'b1, 1'b1, 1'b0, 160'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hFE, 1'b1, 1'b1, 1'b0, 160'h0}
    };

    // Run bookkeeping
    int  faults         = 0;
    int  words_checked  = 0;
    int  items_sent     = 0;   // byte or end requests, idle ones excluded
    int  idle_sent      = 0;
    int  bytes_sent     = 0;
    int  msgs_done      = 0;
    int  two_block_msgs = 0;
    bit  quiet          = 1'b0;   // end of run: no idling on either side
    bit  sender_calm    = 1'b0;   // current message goes without input gaps
    bit  long_hold_done = 1'b0;

    // 80-round compression of sha_block into sha_chain
    function automatic void compress_sha_block();
        word_t w [NUM_WORDS];
        word_t a, b, c, d, e, f, x, t;
        rgrp_t grp;
        int    j;
        w = sha_block;
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (j = 0; j <= LAST_RND; j++)
        begin
            if (j >= 16)
            begin
                x = w[(j + 13) % 16] ^ w[(j + 8) % 16] ^ w[(j + 2) % 16] ^ w[j % 16];
                w[j % 16] = {x[30:0], x[31]};
            end
            grp = rgrp_t'(j / 20);
            case (grp)
                GRP_CH:  f = (b & c) | (~b & d);
                GRP_MAJ: f = (b & c) | (b & d) | (c & d);
                default: f = b ^ c ^ d;
            endcase
            t = {a[26:0], a[31:27]} + f + e + ROUND_K[j / 20] + w[j % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endfunction

    // Big-endian byte placement; first byte of a word clears it
    function automatic void load_byte(input logic [5:0] pos, input logic [7:0] b);
        if (pos[1:0] == 2'd0)
        begin
            sha_block[pos[5:2]] = '0;
        end
        sha_block[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = b;
    endfunction

    // Advances the predictor by one request. Returns 1 when the request closes
    // a message, with the digest packed h0 (top) .. h4 (bottom).
    function automatic bit hash_request(input logic [7:0] d, input logic h, input logic e,
                                        output logic [159:0] dig);
        logic [5:0]  pos;
        logic [63:0] bit_len;
        int          j;
        dig = '0;
        if (h)
        begin
            pos = msg_len[5:0];
            load_byte(pos, d);
            msg_len = msg_len + 61'd1;
            if (pos == 6'd63)
            begin
                compress_sha_block();
            end
        end
        if (!e)
        begin
            return 1'b0;
        end
        // Padding: 0x80, zeros, then the 64-bit bit length in words 14/15.
        // Fewer than 8 free bytes after the pad byte means the length spills into a second block.
        pos = msg_len[5:0];
        load_byte(pos, PAD_BYTE);
        for (j = pos[5:2] + 1; j < NUM_WORDS; j++)
        begin
            sha_block[j] = '0;
        end
        if (pos >= 6'd56)
        begin
            compress_sha_block();
            for (j = 0; j < NUM_WORDS; j++)
            begin
                sha_block[j] = '0;
            end
            two_block_msgs++;
        end
        bit_len = {msg_len, 3'b000};
        sha_block[14] = bit_len[63:32];
        sha_block[15] = bit_len[31:0];
        compress_sha_block();
        for (j = 0; j < NUM_CHAIN; j++)
        begin
            dig[159 - 32 * j -: 32] = sha_chain[j];
        end
        sha_chain = INIT_H;
        msg_len   = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional random gap, then hold the request until accepted.
    // item_valid stays high across back-to-back requests (one NBA per step).
    // On acceptance the predictor runs; a request that closes a message queues
    // the five digest words, or the typed digest for rows with a known vector.
    // ------------------------------------------------------------------------
    task automatic offer_request(input logic [7:0] d, input logic h, input logic e,
                                 input logic known, input logic [159:0] known_dig);
        logic [159:0] dig;
        digest_exp_t  due_word;
        int           j;
        if (!quiet && !sender_calm && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        data_byte      <= d;
        has_byte       <= h;
        end_of_message <= e;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        if (hash_request(d, h, e, dig))
        begin
            if (known)
            begin
                dig = known_dig;
            end
            for (j = 0; j < NUM_CHAIN; j++)
            begin
                due_word.word = dig[159 - 32 * j -: 32];
                due_word.idx  = 3'(j);
                due_word.last = (j == NUM_CHAIN - 1);
                digest_due.insert(digest_due.size(), due_word);
            end
            msgs_done++;
        end
        if (h || e)
        begin
            items_sent++;
        end
        else
        begin
            idle_sent++;
        end
        if (h)
        begin
            bytes_sent++;
        end
        if (items_sent >= QUIET_AT)
        begin
            quiet = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Digest monitor: every accepted word is checked field by field against
    // the oldest queued expectation. Sampled at the edge, before NBA updates.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        digest_exp_t want;
        if (rst_n && digest_valid && digest_ready)
        begin
            if (digest_due.size() == 0)
            begin
                faults++;
                if (faults <= MAX_REPORTS)
                begin
                    $display("unexpected digest word %h index %0d last %0b",
                             digest_word, word_index, last_word);
                end
            end
            else
            begin
                want = digest_due.pop_front();
                if (digest_word !== want.word || word_index !== want.idx ||
                    last_word !== want.last)
                begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                    begin
                        $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                 want.word, want.idx, want.last,
                                 digest_word, word_index, last_word);
                    end
                end
            end
            words_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Digest-side backpressure: random ready bursts, one long hold once a few
    // digests have gone through (the input must stall behind it), and ready
    // held high in the quiet tail of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && words_checked >= 10)
            begin
                digest_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                digest_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                digest_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog: fails the run if it has not finished by the timeout
    initial
    begin
        #4_000_000;
        $display("sha1_stream_hash regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int forced_lens [$] = '{55, 56, 63, 64};   // around the padding boundary
        int len;
        int k;
        int pick;
        bit bare_end;

        sha_chain = INIT_H;
        msg_len   = '0;
        for (k = 0; k < NUM_WORDS; k++)
        begin
            sha_block[k] = '0;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (k = 0; k < NUM_DIR; k++)
        begin
            offer_request(dir_rows[k].data, dir_rows[k].has, dir_rows[k].eom,
                          dir_rows[k].known, dir_rows[k].digest);
        end

        // Random messages: boundary lengths first, then mostly short ones.
        // Idle requests are sprinkled in as noise; the end comes either on
        // the last byte or as a separate bare end request.
        while (items_sent < ITEMS_TARGET)
        begin
            if (forced_lens.size() > 0)
            begin
                len = forced_lens.pop_front();
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    len = $urandom_range(0, 12);
                end
                else if (pick < 9)
                begin
                    len = $urandom_range(13, 70);
                end
                else
                begin
                    len = $urandom_range(71, 130);
                end
            end
            sender_calm = ($urandom_range(0, 3) == 0);
            bare_end    = (len == 0) || ($urandom_range(0, 1) == 1);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                end
                offer_request(8'($urandom_range(0, 255)), 1'b1,
                              (k == len - 1) && !bare_end, 1'b0, '0);
            end
            if (bare_end)
            begin
                offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            end
        end
        item_valid <= 1'b0;

        // Drain: all digests in, then a quiet window for stray outputs
        while (digest_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d messages (%0d with a two-block tail), %0d bytes, %0d idle requests",
                 msgs_done, two_block_msgs, bytes_sent, idle_sent);
        $display("checked %0d digest words, %0d mismatches", words_checked, faults);
        if (faults == 0 && digest_due.size() == 0)
        begin
            $display("sha1_stream_hash regression: pass");
        end
        else
        begin
            $display("sha1_stream_hash regression: fail");
        end
        $finish;
    end

endmodule
